### rtl/mnsd_pkg.sv
// shared types, constants and helpers for the matrix norm screen decision unit
`default_nettype none
package mnsd_pkg;
    localparam int MAX_COLUMNS    = 256;
    localparam int MAX_ROW_LENGTH = 65536;
    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int CCNT_W = 9;
    localparam int RLEN_W = 17;

    localparam logic [2:0] DEC_NONE = 3'd0;
    localparam logic [2:0] DEC_T1   = 3'd1;
    localparam logic [2:0] DEC_T2   = 3'd2;
    localparam logic [2:0] DEC_T3   = 3'd3;
    localparam logic [2:0] DEC_T4   = 3'd4;

    localparam logic REG_ENABLE    = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic       acc;        // accumulate the captured element
        logic       sqrt_start; // begin root extraction of both maxima
        logic       sqrt_step;  // one root iteration
        logic       prod_load;  // load test operands for test index
        logic [1:0] test_sel;   // 0 term4, 1 term3, 2 term2, 3 term1
        logic       mul1;       // first multiply stage
        logic       mul2;       // second multiply stage
        logic       clear_job;
    } mnsd_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic pass;     // last triple product beat the threshold
    } mnsd_sts_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction
endpackage
`default_nettype wire

### rtl/mnsd_ram.sv
// generic ram with one write port, one read port and registered read
`default_nettype none
module mnsd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/mnsd_datapath.sv
// accumulators, column ram, root extraction and threshold products
`default_nettype none
module mnsd_datapath (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire mnsd_pkg::mnsd_cmd_t       cmd,
    input  wire logic                      cap,
    input  wire logic [31:0]               element_value,
    input  wire logic [16:0]               row_length,
    input  wire logic [8:0]                column_count,
    input  wire logic                      last_element,
    input  wire logic [31:0]               c1_factor,
    input  wire logic [31:0]               c3_factor,
    input  wire logic [31:0]               d34_factor,
    input  wire logic [31:0]               d14_factor,
    input  wire logic [31:0]               d32_factor,
    input  wire logic [31:0]               d12_factor,
    input  wire logic [63:0]               cut_threshold,
    output mnsd_pkg::mnsd_sts_t            sts,
    output logic [31:0]                    row_norm,
    output logic [31:0]                    col_norm
);
    // captured request fields
    logic [31:0] mag_reg;
    logic        last_reg;
    logic [mnsd_pkg::CCNT_W-1:0] ccnt_reg;
    logic [mnsd_pkg::RLEN_W-1:0] rlen_reg;
    logic [31:0] c1_reg, c3_reg, d34_reg, d14_reg, d32_reg, d12_reg;

    logic [mnsd_pkg::CCNT_W-1:0] ccnt_c;
    logic [mnsd_pkg::RLEN_W-1:0] rlen_c;
    always_comb begin
        ccnt_c = column_count;
        if (ccnt_c == '0) ccnt_c = 9'd1;
        if (ccnt_c > 9'(mnsd_pkg::MAX_COLUMNS)) ccnt_c = 9'(mnsd_pkg::MAX_COLUMNS);
        rlen_c = row_length;
        if (rlen_c == '0) rlen_c = 17'd1;
        if (rlen_c > 17'(mnsd_pkg::MAX_ROW_LENGTH)) rlen_c = 17'(mnsd_pkg::MAX_ROW_LENGTH);
    end

    always_ff @(posedge aclk) begin
        if (cap) begin
            mag_reg  <= element_value[31] ? (~element_value + 32'd1) : element_value;
            last_reg <= last_element;
            ccnt_reg <= ccnt_c;
            rlen_reg <= rlen_c;
            c1_reg <= c1_factor;   c3_reg <= c3_factor;
            d34_reg <= d34_factor; d14_reg <= d14_factor;
            d32_reg <= d32_factor; d12_reg <= d12_factor;
        end
    end

    // column position decided at capture so the ram read is ready for acc
    logic [mnsd_pkg::CCNT_W:0]  colpos_reg;
    logic [mnsd_pkg::RLEN_W:0]  rowpos_reg;
    logic [mnsd_pkg::COL_W-1:0] col_reg;
    logic [mnsd_pkg::RLEN_W-1:0] row_reg;
    logic        first_row_reg;
    logic [63:0] row_sum_reg, best_row_reg, best_col_reg;
    logic [63:0] ram_rdata, col_new;
    logic [63:0] sq;

    logic [mnsd_pkg::CCNT_W:0] col_sel;
    assign col_sel = (colpos_reg < {1'b0, ccnt_c}) ? colpos_reg : '0;

    always_ff @(posedge aclk) begin
        if (cap) begin
            col_reg <= col_sel[mnsd_pkg::COL_W-1:0];
            row_reg <= (rowpos_reg < {1'b0, rlen_c}) ? rowpos_reg[mnsd_pkg::RLEN_W-1:0] : '0;
        end
    end

    mnsd_ram #(.WIDTH(64), .DEPTH(mnsd_pkg::MAX_COLUMNS)) u_colram (
        .aclk  (aclk),
        .we    (cmd.acc),
        .waddr (col_reg),
        .wdata (col_new),
        .raddr (col_sel[mnsd_pkg::COL_W-1:0]),
        .rdata (ram_rdata)
    );

    assign sq = 64'(mag_reg) * 64'(mag_reg);
    assign col_new = first_row_reg ? sq : mnsd_pkg::sat_add(ram_rdata, sq);

    logic [63:0] row_sum_new;
    assign row_sum_new = mnsd_pkg::sat_add(row_sum_reg, sq);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_job) begin
            colpos_reg <= '0;
            rowpos_reg <= '0;
            first_row_reg <= 1'b1;
            row_sum_reg <= '0;
            best_row_reg <= '0;
            best_col_reg <= '0;
        end else if (cmd.acc) begin
            if (col_new > best_col_reg) best_col_reg <= col_new;
            if ({1'b0, col_reg} + 10'd1 >= {1'b0, ccnt_reg}) begin
                colpos_reg <= '0;
                first_row_reg <= 1'b0;
            end else begin
                colpos_reg <= {1'b0, col_reg} + 10'd1;
            end
            if ({1'b0, row_reg} + 18'd1 >= {1'b0, rlen_reg} || last_reg) begin
                if (row_sum_new > best_row_reg) best_row_reg <= row_sum_new;
                row_sum_reg <= '0;
                rowpos_reg <= '0;
            end else begin
                row_sum_reg <= row_sum_new;
                rowpos_reg <= {1'b0, row_reg} + 18'd1;
            end
        end
    end

    // two restoring square roots, one result bit per step
    logic [63:0] rx_reg, cx_reg;
    logic [33:0] rr_reg, cr_reg;
    logic [63:0] rrem_reg, crem_reg;
    logic [5:0]  sq_cnt_reg;

    logic [65:0] rtrial, ctrial, rcur, ccur;
    always_comb begin
        rcur   = {rrem_reg[63:0], rx_reg[63:62]};
        ccur   = {crem_reg[63:0], cx_reg[63:62]};
        rtrial = {30'd0, rr_reg, 2'b01};
        ctrial = {30'd0, cr_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_cnt_reg <= '0;
        end else if (cmd.sqrt_start) begin
            rx_reg <= best_row_reg; cx_reg <= best_col_reg;
            rr_reg <= '0; cr_reg <= '0;
            rrem_reg <= '0; crem_reg <= '0;
            sq_cnt_reg <= 6'd32;
        end else if (cmd.sqrt_step && sq_cnt_reg != '0) begin
            rx_reg <= {rx_reg[61:0], 2'b00};
            cx_reg <= {cx_reg[61:0], 2'b00};
            if (rcur >= rtrial) begin
                rrem_reg <= 64'(rcur - rtrial);
                rr_reg <= {rr_reg[32:0], 1'b1};
            end else begin
                rrem_reg <= 64'(rcur);
                rr_reg <= {rr_reg[32:0], 1'b0};
            end
            if (ccur >= ctrial) begin
                crem_reg <= 64'(ccur - ctrial);
                cr_reg <= {cr_reg[32:0], 1'b1};
            end else begin
                crem_reg <= 64'(ccur);
                cr_reg <= {cr_reg[32:0], 1'b0};
            end
            sq_cnt_reg <= sq_cnt_reg - 6'd1;
        end
    end
    assign sts.sqrt_done = (sq_cnt_reg == '0);
    assign row_norm = rr_reg[31:0];
    assign col_norm = cr_reg[31:0];

    // triple product: a*b registered, then two 32x32 partials
    logic [31:0] pa_reg, pb_reg, pc_reg, pc2_reg;
    logic [63:0] p_reg;
    logic [63:0] hi_reg, lo_reg;
    always_ff @(posedge aclk) begin
        if (cmd.prod_load) begin
            case (cmd.test_sel)
                2'd0: begin pa_reg <= c1_reg; pb_reg <= rr_reg[31:0]; pc_reg <= d34_reg; end
                2'd1: begin pa_reg <= c3_reg; pb_reg <= rr_reg[31:0]; pc_reg <= d14_reg; end
                2'd2: begin pa_reg <= c1_reg; pb_reg <= cr_reg[31:0]; pc_reg <= d32_reg; end
                default: begin pa_reg <= c3_reg; pb_reg <= cr_reg[31:0]; pc_reg <= d12_reg; end
            endcase
        end
        if (cmd.mul1) begin
            p_reg <= 64'(pa_reg) * 64'(pb_reg);
            pc2_reg <= pc_reg;
        end
        if (cmd.mul2) begin
            hi_reg <= 64'(p_reg[63:32]) * 64'(pc2_reg);
            lo_reg <= 64'(p_reg[31:0]) * 64'(pc2_reg);
        end
    end

    logic [63:0] tp;
    assign tp = (hi_reg[63:56] != '0) ? '1
              : mnsd_pkg::sat_add({hi_reg[55:0], 8'd0}, {24'd0, lo_reg[63:24]});
    assign sts.pass = tp > cut_threshold;

`ifndef SYNTHESIS
    a_sqrt_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sqrt_start |=> sq_cnt_reg == 6'd32)
        else $error("root counter not loaded");
    a_clear_first: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_job |=> first_row_reg && row_sum_reg == '0)
        else $error("job state not cleared");
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.acc |-> {1'b0, col_reg} < ccnt_reg)
        else $error("column index out of range");
`endif
endmodule
`default_nettype wire

### rtl/mnsd_ctrl.sv
// sequencing state machine for accumulation, roots and the test chain
`default_nettype none
module mnsd_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_fire,
    input  wire logic                s_last,
    input  wire logic [2:0]          s_mode,
    input  wire logic                screen_enable,
    input  wire mnsd_pkg::mnsd_sts_t sts,
    input  wire logic                m_fire,
    output mnsd_pkg::mnsd_cmd_t      cmd,
    output logic                     busy,
    output logic                     m_valid,
    output logic [2:0]               decision
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_MUL1 = 3'd4;
    localparam logic [2:0] ST_MUL2 = 3'd5;
    localparam logic [2:0] ST_CMP  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] test_reg, test_next;
    logic       last_reg, sqrt_go_reg;
    logic [2:0] mode_reg;
    logic [2:0] dec_reg, dec_next;
    logic       rows_on;

    assign rows_on = (mode_reg == 3'd3) || (mode_reg == 3'd4);

    always_comb begin
        state_next = state_reg;
        test_next  = test_reg;
        dec_next   = dec_reg;
        cmd = '0;
        cmd.test_sel = test_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (!sqrt_go_reg) begin
                    cmd.sqrt_start = 1'b1;
                end else if (sts.sqrt_done) begin
                    if (!screen_enable) begin
                        dec_next = mnsd_pkg::DEC_T4;
                        state_next = ST_OUT;
                    end else if (mode_reg == 3'd1 || mode_reg == 3'd2) begin
                        test_next = 2'd2;
                        state_next = ST_LOAD;
                    end else if (rows_on) begin
                        test_next = 2'd0;
                        state_next = ST_LOAD;
                    end else begin
                        dec_next = mnsd_pkg::DEC_NONE;
                        state_next = ST_OUT;
                    end
                end else begin
                    cmd.sqrt_step = 1'b1;
                end
            end
            ST_LOAD: begin
                cmd.prod_load = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1 = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2 = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (sts.pass) begin
                    dec_next = 3'(3'd4 - {1'b0, test_reg});
                    state_next = ST_OUT;
                end else if (test_reg == 2'd3) begin
                    dec_next = mnsd_pkg::DEC_NONE;
                    state_next = ST_OUT;
                end else begin
                    test_next = test_reg + 2'd1;
                    state_next = ST_LOAD;
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    cmd.clear_job = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            test_reg <= '0;
            dec_reg <= '0;
            sqrt_go_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            test_reg <= test_next;
            dec_reg <= dec_next;
            sqrt_go_reg <= (state_reg == ST_SQRT);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            last_reg <= s_last;
            mode_reg <= s_mode;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign decision = dec_reg;

`ifndef SYNTHESIS
    a_out_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fire) |=> state_reg == ST_IDLE)
        else $error("result not retired");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> state_reg == ST_IDLE)
        else $error("request taken while busy");
    a_dec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> decision <= mnsd_pkg::DEC_T4)
        else $error("decision out of range");
`endif
endmodule
`default_nettype wire

### rtl/matrix_norm_screen_decision_unit.sv
// top level: stream ports, register file, controller and datapath
// each element is captured, then accumulated; the last element also adds root
// extraction (load, 32 one-bit steps, finish) and up to 4 threshold tests
// an element is not taken until the previous one's column ram read-modify-write is done
// the result waits in its register until taken; no request is accepted meanwhile
// reset: synchronous active-low aresetn clears control, registers and job sums;
// the column ram is not cleared, the first row of every job overwrites it
`default_nettype none
module matrix_norm_screen_decision_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // element_value[31:0], row_length[48:32], column_count[57:49], start_mode[60:58],
    // c1[92:61], c3[124:93], d34[156:125], d14[188:157], d32[220:189], d12[252:221]
    input  wire logic [255:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // decision[2:0], row_norm_max[34:3], column_norm_max[66:35]
    output logic [71:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    logic        enable_reg;
    logic [63:0] threshold_reg;
    logic        busy, s_fire, m_fire;
    logic [2:0]  decision;
    logic [31:0] row_norm, col_norm;
    mnsd_pkg::mnsd_cmd_t cmd;
    mnsd_pkg::mnsd_sts_t sts;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            threshold_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0
                     && paddr[3:3] == mnsd_pkg::REG_ENABLE) begin
            enable_reg <= pwdata[0];
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0
                     && paddr[3:3] == mnsd_pkg::REG_THRESHOLD) begin
            threshold_reg <= pwdata;
        end
    end
    always_comb begin
        prdata = '0;
        case (paddr[3:3])
            mnsd_pkg::REG_ENABLE:    prdata = {63'd0, enable_reg};
            default:                 prdata = threshold_reg;
        endcase
    end

    assign s_tready = !busy;
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    mnsd_ctrl u_ctrl (
        .aclk (aclk), .aresetn (aresetn),
        .s_fire (s_fire), .s_last (s_tlast), .s_mode (s_tdata[60:58]),
        .screen_enable (enable_reg), .sts (sts), .m_fire (m_fire),
        .cmd (cmd), .busy (busy), .m_valid (m_tvalid), .decision (decision)
    );

    mnsd_datapath u_dp (
        .aclk (aclk), .aresetn (aresetn), .cmd (cmd), .cap (s_fire),
        .element_value (s_tdata[31:0]), .row_length (s_tdata[48:32]),
        .column_count (s_tdata[57:49]), .last_element (s_tlast),
        .c1_factor (s_tdata[92:61]), .c3_factor (s_tdata[124:93]),
        .d34_factor (s_tdata[156:125]), .d14_factor (s_tdata[188:157]),
        .d32_factor (s_tdata[220:189]), .d12_factor (s_tdata[252:221]),
        .cut_threshold (threshold_reg), .sts (sts),
        .row_norm (row_norm), .col_norm (col_norm)
    );

    assign m_tdata = {5'd0, col_norm, row_norm, decision};
endmodule
`default_nettype wire

### tb/testbench.sv
// testbench for the matrix norm screen decision unit: random jobs checked against a scoreboard
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    typedef struct {
        logic [31:0] elem;
        logic [16:0] rlen;
        logic [8:0]  ccount;
        logic        last;
        logic [2:0]  mode;
        logic [31:0] c1, c3, d34, d14, d32, d12;
    } element_t;

    typedef struct {
        logic [2:0]  decision;
        logic [31:0] row_norm;
        logic [31:0] col_norm;
    } decision_t;

    class screen_scoreboard;
        logic        enable;
        logic [63:0] threshold;
        logic [63:0] col_sums [mnsd_pkg::MAX_COLUMNS];
        logic [63:0] row_sum, best_row, best_col;
        int unsigned col_pos, row_pos;
        bit          first_row;
        decision_t   pending [$];
        int          errors;

        function new();
            enable = 0;
            threshold = 0;
            errors = 0;
            foreach (col_sums[i]) col_sums[i] = 0;
            clear_job();
        endfunction

        function void clear_job();
            row_sum = 0;
            best_row = 0;
            best_col = 0;
            col_pos = 0;
            row_pos = 0;
            first_row = 1;
        endfunction

        function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        endfunction

        function logic [63:0] root(logic [63:0] x);
            logic [63:0] r, b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // factor * norm * density, shifted down 24 and saturated to Q40.24
        function bit beats(logic [31:0] a, logic [31:0] n, logic [31:0] d);
            logic [127:0] p;
            logic [63:0]  q;
            p = ({96'd0, a} * {96'd0, n} * {96'd0, d}) >> 24;
            q = (p[127:64] != 0) ? '1 : p[63:0];
            return q > threshold;
        endfunction

        function void note(element_t e);
            logic [31:0] mag;
            logic [63:0] sq;
            int unsigned rl, cc, col, row;
            decision_t   res;
            bit          done;
            mag = e.elem[31] ? -e.elem : e.elem;
            sq = {32'd0, mag} * {32'd0, mag};
            rl = e.rlen;
            cc = e.ccount;
            if (rl == 0) rl = 1;
            if (rl > mnsd_pkg::MAX_ROW_LENGTH) rl = mnsd_pkg::MAX_ROW_LENGTH;
            if (cc == 0) cc = 1;
            if (cc > mnsd_pkg::MAX_COLUMNS) cc = mnsd_pkg::MAX_COLUMNS;
            col = (col_pos < cc) ? col_pos : 0;
            row = (row_pos < rl) ? row_pos : 0;
            col_sums[col] = first_row ? sq : add_sat(col_sums[col], sq);
            if (col_sums[col] > best_col) best_col = col_sums[col];
            if (col + 1 >= cc) begin
                col_pos = 0;
                first_row = 0;
            end else begin
                col_pos = col + 1;
            end
            row_sum = add_sat(row_sum, sq);
            if (row + 1 >= rl || e.last) begin
                if (row_sum > best_row) best_row = row_sum;
                row_sum = 0;
                row_pos = 0;
            end else begin
                row_pos = row + 1;
            end
            if (!e.last) return;
            res.row_norm = root(best_row);
            res.col_norm = root(best_col);
            res.decision = mnsd_pkg::DEC_NONE;
            if (!enable) begin
                res.decision = mnsd_pkg::DEC_T4;
            end else if (e.mode >= 1 && e.mode <= 4) begin
                done = 0;
                if (e.mode >= 3) begin
                    if (beats(e.c1, res.row_norm, e.d34)) begin
                        res.decision = mnsd_pkg::DEC_T4;
                        done = 1;
                    end else if (beats(e.c3, res.row_norm, e.d14)) begin
                        res.decision = mnsd_pkg::DEC_T3;
                        done = 1;
                    end
                end
                if (!done) begin
                    if (beats(e.c1, res.col_norm, e.d32)) res.decision = mnsd_pkg::DEC_T2;
                    else if (beats(e.c3, res.col_norm, e.d12)) res.decision = mnsd_pkg::DEC_T1;
                end
            end
            pending.push_back(res);
            clear_job();
        endfunction

        function void check(logic [71:0] data);
            decision_t exp_res;
            if (pending.size() == 0) begin
                $error("decision arrived with none outstanding: %h", data);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (data[2:0] !== exp_res.decision) begin
                $error("decision: expected %0d, got %0d", exp_res.decision, data[2:0]);
                errors++;
            end
            if (data[34:3] !== exp_res.row_norm) begin
                $error("row_norm_max: expected %h, got %h", exp_res.row_norm, data[34:3]);
                errors++;
            end
            if (data[66:35] !== exp_res.col_norm) begin
                $error("column_norm_max: expected %h, got %h", exp_res.col_norm, data[66:35]);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;   // element, row_length, column_count, start_mode, c1..d12
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [71:0]  m_tdata;        // decision, row_norm_max, column_norm_max
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [3:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    screen_scoreboard sb = new();
    bit calm = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int sent = 0;

    always #2 aclk = ~aclk;

    matrix_norm_screen_decision_unit dut (.*);

    task automatic reg_write(logic index, logic [63:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 4'(8 * int'(index));
        pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (index == mnsd_pkg::REG_ENABLE) sb.enable = value[0];
        else sb.threshold = value;
    endtask

    task automatic send(element_t e);
        bit r;
        s_tvalid <= 1;
        s_tlast <= e.last;
        s_tdata <= {3'd0, e.d12, e.d32, e.d14, e.d34, e.c3, e.c1, e.mode, e.ccount,
                    e.rlen, e.elem};
        do begin
            @(negedge aclk);
            r = s_tready;
            @(posedge aclk);
        end while (!r);
        sb.note(e);
        sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [31:0] factor();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'h0100_0000;
            default: return $urandom_range(32'h0040_0000, 32'h0400_0000);
        endcase
    endfunction

    function automatic element_t make(logic [31:0] v, logic [16:0] rl, logic [8:0] cc,
                                      logic last, logic [2:0] mode);
        element_t e;
        e.elem = v;
        e.rlen = rl;
        e.ccount = cc;
        e.last = last;
        e.mode = mode;
        e.c1 = factor();
        e.c3 = factor();
        e.d34 = factor();
        e.d14 = factor();
        e.d32 = factor();
        e.d12 = factor();
        return e;
    endfunction

    function automatic int eff_cols(logic [8:0] cc);
        if (cc == 0) return 1;
        return (cc > mnsd_pkg::MAX_COLUMNS) ? mnsd_pkg::MAX_COLUMNS : cc;
    endfunction

    task automatic random_job();
        int          n, cap;
        logic [8:0]  cc, c2;
        logic [16:0] rl;
        logic [31:0] v;
        logic [2:0]  mode;
        if ($urandom_range(0, 30) == 0) begin
            cc = 9'($urandom_range(256, 511));
            n = $urandom_range(256, 520);
        end else begin
            cc = 9'($urandom_range(0, 8));
            n = $urandom_range(1, 30);
        end
        case ($urandom_range(0, 9))
            0: rl = 17'($urandom_range(65536, 131071));
            1: rl = 0;
            default: rl = 17'($urandom_range(1, 12));
        endcase
        cap = eff_cols(cc);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: v = $urandom();
                1: v = {{7{$urandom_range(0, 1) == 1}}, 25'($urandom())};
                default: v = {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
            endcase
            // column count never grows within a job
            if (cap > 1 && $urandom_range(0, 15) == 0) begin
                c2 = 9'($urandom_range(1, cap));
                cc = c2;
                cap = eff_cols(c2);
            end
            if ($urandom_range(0, 20) == 0) rl = 17'($urandom_range(1, 12));
            mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(1, 4));
            send(make(v, rl, cc, i == n - 1, mode));
        end
    endtask

    // result side: random stalls and one long hold-off
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 0;
                repeat (400) @(posedge aclk);
                hold_req = 0;
                m_tready <= 1;
                @(posedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    always @(negedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata);

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [63:0] thr;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset state: screening off
        send(make(32'h7FFF_FFFF, 17'd1, 9'd1, 1, 3'd4));
        drain();
        reg_write(mnsd_pkg::REG_ENABLE, 64'd1);
        reg_write(mnsd_pkg::REG_THRESHOLD, 64'd0);
        send(make(32'h8000_0000, 17'd0, 9'd0, 1, 3'd3));
        send(make(32'h0000_0000, 17'd1, 9'd1, 1, 3'd1));
        send(make(32'h0100_0000, 17'd131071, 9'd511, 0, 3'd2));
        send(make(32'hFF00_0000, 17'd131071, 9'd511, 1, 3'd0));
        // odd start modes
        send(make(32'h0200_0000, 17'd2, 9'd2, 1, 3'd5));
        send(make(32'h0200_0000, 17'd2, 9'd2, 1, 3'd7));
        // partial last row, then sizes shrinking mid-matrix
        send(make(32'h0123_4567, 17'd4, 9'd4, 0, 3'd4));
        send(make(32'hF123_4567, 17'd4, 9'd4, 0, 3'd4));
        send(make(32'h0000_0001, 17'd4, 9'd4, 1, 3'd4));
        send(make(32'h0300_0000, 17'd6, 9'd3, 0, 3'd3));
        send(make(32'h0400_0000, 17'd6, 9'd3, 0, 3'd3));
        send(make(32'h0500_0000, 17'd6, 9'd3, 0, 3'd3));
        send(make(32'h0600_0000, 17'd2, 9'd1, 0, 3'd3));
        send(make(32'h8000_0001, 17'd2, 9'd1, 1, 3'd3));
        drain();
        reg_write(mnsd_pkg::REG_THRESHOLD, '1);
        send(make(32'h7FFF_FFFF, 17'd1, 9'd1, 1, 3'd4));
        send(make(32'h8000_0000, 17'd1, 9'd1, 1, 3'd2));
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: thr = 64'($urandom_range(0, 255)) << 40;
                1: thr = {$urandom(), $urandom()};
                2: thr = '1;
                default: thr = 64'($urandom()) << $urandom_range(8, 24);
            endcase
            reg_write(mnsd_pkg::REG_ENABLE,
                      (ph == 5) ? 64'd0 : {$urandom(), $urandom()} | 64'd1);
            reg_write(mnsd_pkg::REG_THRESHOLD, (ph == 0) ? 64'd0 : thr);
            if (ph == 10) calm = 1;
            while (sent < 90 * (ph + 1) + 20) begin
                if (ph == 3 && !hold_done && sent > 300) begin
                    hold_req = 1;
                    hold_done = 1;
                end
                random_job();
            end
            drain();
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
